// ===== sv/cps_pkg.sv =====
// cps_pkg: shared types and constants for the can payload segmenter
// no dependencies; imported by every module of the block

package cps_pkg;

  localparam int MAX_FRAMES   = 32;
  localparam int SEQ_W        = 5;
  localparam int CHUNK_BYTES  = 7;
  localparam int ID_W         = 11;
  localparam int PAYLOAD_W    = 8 * CHUNK_BYTES;

  localparam logic [ID_W-1:0]  ID_RESET   = 11'h4BA;
  localparam logic [7:0]       FINAL_HDR  = 8'hF8;
  localparam logic [7:0]       MIDDLE_LOW = 8'h07;
  localparam logic [3:0]       FULL_LEN   = 4'd8;
  localparam logic [SEQ_W-1:0] LAST_SEQ   = SEQ_W'(MAX_FRAMES - 1);

  typedef struct packed {
    logic [ID_W-1:0]      frame_id;
    logic [3:0]           frame_len;
    logic [7:0]           header_byte;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last_frame;
    logic [7:0]           bytes_sent;
  } frame_t;

endpackage

// ===== sv/cps_segment.sv =====
// cps_segment: message state registers and frame forming logic
// depends on cps_pkg

module cps_segment
  import cps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [ID_W-1:0]  cfg_wdata,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             emit,
  output frame_t           frame
);

  logic [ID_W-1:0]                  frame_identifier;
  logic [SEQ_W-1:0]                 seq_count, seq_count_next;
  logic [2:0]                       fill_count, fill_count_next;
  logic [CHUNK_BYTES-1:0][7:0]      pending_bytes, pending_bytes_next;
  logic [7:0]                       total_sent, total_sent_next;
  logic                             discarding, discarding_next;

  logic [CHUNK_BYTES-1:0][7:0]      merged;
  logic [2:0]                       count;
  logic [7:0]                       total_last;
  logic [7:0]                       total_full;

  always_comb begin
    merged = pending_bytes;
    if (fill_count < 3'(CHUNK_BYTES)) begin
      merged[fill_count] = data_byte;
    end
  end

  assign count      = fill_count + 3'd1;
  assign total_last = total_sent + {5'd0, count};
  assign total_full = total_sent + 8'(CHUNK_BYTES);

  always_comb begin
    seq_count_next     = seq_count;
    fill_count_next    = fill_count;
    pending_bytes_next = pending_bytes;
    total_sent_next    = total_sent;
    discarding_next    = discarding;
    emit               = 1'b0;
    frame.frame_id     = frame_identifier;
    frame.frame_len    = FULL_LEN;
    frame.header_byte  = {seq_count, 3'b111};
    frame.payload      = merged;
    frame.last_frame   = 1'b0;
    frame.bytes_sent   = total_full;
    if (step) begin
      if (discarding) begin
        if (last_byte) begin
          discarding_next = 1'b0;
        end
      end else if (last_byte) begin
        // final frame, partial or full chunk
        emit               = 1'b1;
        frame.frame_len    = {1'b0, count} + 4'd1;
        frame.header_byte  = FINAL_HDR | {5'd0, count};
        frame.last_frame   = 1'b1;
        frame.bytes_sent   = total_last;
        seq_count_next     = '0;
        fill_count_next    = '0;
        pending_bytes_next = '0;
        total_sent_next    = '0;
      end else if (count < 3'(CHUNK_BYTES)) begin
        fill_count_next    = count;
        pending_bytes_next = merged;
      end else begin
        emit               = 1'b1;
        fill_count_next    = '0;
        pending_bytes_next = '0;
        if (seq_count == LAST_SEQ) begin
          // frame limit hit: end the message and drop the rest
          frame.last_frame = 1'b1;
          seq_count_next   = '0;
          total_sent_next  = '0;
          discarding_next  = 1'b1;
        end else begin
          seq_count_next   = seq_count + SEQ_W'(1);
          total_sent_next  = total_full;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_identifier <= ID_RESET;
      seq_count        <= '0;
      fill_count       <= '0;
      pending_bytes    <= '0;
      total_sent       <= '0;
      discarding       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        frame_identifier <= cfg_wdata;
      end
      seq_count     <= seq_count_next;
      fill_count    <= fill_count_next;
      pending_bytes <= pending_bytes_next;
      total_sent    <= total_sent_next;
      discarding    <= discarding_next;
    end
  end

endmodule

// ===== sv/cps_out_buf.sv =====
// cps_out_buf: two-entry output stage (result register plus skid)
// depends on cps_pkg

module cps_out_buf
  import cps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  output logic   space,
  output logic   out_valid,
  input  logic   out_ready,
  output frame_t out_frame
);

  logic   main_valid, main_valid_next;
  logic   skid_valid, skid_valid_next;
  frame_t main_frame, main_frame_next;
  frame_t skid_frame, skid_frame_next;
  logic   pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_frame = main_frame;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_frame_next = main_frame;
    skid_frame_next = skid_frame;
    if (pop) begin
      main_valid_next = skid_valid;
      main_frame_next = skid_frame;
      skid_valid_next = 1'b0;
    end
    if (push) begin
      if (!main_valid_next) begin
        main_valid_next = 1'b1;
        main_frame_next = push_frame;
      end else begin
        skid_valid_next = 1'b1;
        skid_frame_next = push_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
    main_frame <= main_frame_next;
    skid_frame <= skid_frame_next;
  end

endmodule

// ===== sv/can_payload_segmenter.sv =====
// can_payload_segmenter: top level, splits a byte stream into can frames
// depends on cps_pkg, cps_segment and cps_out_buf

// The block takes one message byte per request and packs bytes into frames of
// a header byte plus up to seven payload bytes. A full chunk that is not the
// end of the message leaves as a middle frame (header seq<<3|7, length 8); the
// byte flagged last closes the message with a final frame (header 0xF8|count,
// length count+1). The 32nd frame of a message ends it, and later bytes are
// dropped up to and including the next last byte. Every frame carries the
// configured identifier (reset 0x4BA) and the running payload byte total.
// Rate: one byte per clock while in_ready is high. A byte updates the message
// registers in the cycle it is taken; the frame it completes is registered in
// the result register, or in a one-entry skid behind it while that still holds
// a frame, so in_ready drops only when both hold frames not yet taken.
// The identifier register should be written only while no message is in
// flight.

module can_payload_segmenter
  import cps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_wen,
  input  logic [ID_W-1:0]      cfg_wdata,
  // byte input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  // frame output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      frame_id,
  output logic [3:0]           frame_len,
  output logic [7:0]           header_byte,
  output logic [PAYLOAD_W-1:0] payload,
  output logic                 last_frame,
  output logic [7:0]           bytes_sent
);

  logic   step;       // byte request taken this cycle
  logic   emit;       // that byte completes a frame
  frame_t new_frame;
  frame_t out_frame;

  assign step = in_valid && in_ready;

  // message state and frame forming
  cps_segment u_segment (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .emit      (emit),
    .frame     (new_frame)
  );

  // result register plus skid entry
  cps_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (emit),
    .push_frame (new_frame),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_frame  (out_frame)
  );

  assign frame_id    = out_frame.frame_id;
  assign frame_len   = out_frame.frame_len;
  assign header_byte = out_frame.header_byte;
  assign payload     = out_frame.payload;
  assign last_frame  = out_frame.last_frame;
  assign bytes_sent  = out_frame.bytes_sent;

endmodule

// ===== sv/cps_checker.sv =====
// cps_checker: port-level checks on the segmenter, bound to the top level
// depends on cps_pkg and can_payload_segmenter

module cps_checker
  import cps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [3:0]           frame_len,
  input logic [7:0]           header_byte,
  input logic                 last_frame,
  input logic [7:0]           bytes_sent
);

  // a stalled frame stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("frame dropped while stalled");

  // a byte request waits only behind a frame that has not been taken
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("byte request stalled with no frame pending");

  // middle frames are always full
  a_middle_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_frame |-> frame_len == FULL_LEN && header_byte[2:0] == 3'b111)
    else $error("middle frame not full");

  // length code follows the byte count in the header of a closing frame
  a_final_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_frame |-> header_byte[7:3] == 5'h1f &&
      frame_len == {1'b0, header_byte[2:0]} + 4'd1)
    else $error("final frame header and length disagree");

  // at least one payload byte sent with every frame
  a_sent_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bytes_sent != 8'd0 && frame_len >= 4'd2)
    else $error("frame with no payload bytes");

endmodule

bind can_payload_segmenter cps_checker u_cps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_len   (frame_len),
  .header_byte (header_byte),
  .last_frame  (last_frame),
  .bytes_sent  (bytes_sent)
);

// ===== sim/can_payload_segmenter_tb.sv =====
// can_payload_segmenter_tb: self-checking bench for the can payload segmenter
// drives byte requests, predicts every frame and checks the frame stream
// depends on cps_pkg and can_payload_segmenter

module can_payload_segmenter_tb;
  import cps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles before the watchdog calls the run dead
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  // cycles allowed for a frame still in the result register or skid
  localparam int unsigned SETTLE_CYCLES   = 8;
  // at least this many byte requests queued per idling phase (messages are never split)
  localparam int unsigned PHASE_BYTES     = 400;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned REPORT_LIMIT    = 10;

  // one byte request as the sender will present it
  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         drain_first;   // hold off until every frame has come
  } byte_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [ID_W-1:0]      cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ID_W-1:0]      frame_id;
  logic [3:0]           frame_len;
  logic [7:0]           header_byte;
  logic [PAYLOAD_W-1:0] payload;
  logic                 last_frame;
  logic [7:0]           bytes_sent;

  can_payload_segmenter DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_id    (frame_id),
    .frame_len   (frame_len),
    .header_byte (header_byte),
    .payload     (payload),
    .last_frame  (last_frame),
    .bytes_sent  (bytes_sent)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // segmenter shadow state, updated once per accepted byte request
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]      can_ident    = ID_RESET;
  logic [SEQ_W-1:0]     frame_seq    = '0;
  logic [2:0]           chunk_fill   = '0;
  logic [PAYLOAD_W-1:0] chunk_bytes  = '0;
  logic [7:0]           msg_total    = '0;
  bit                   skipping     = 1'b0;

  frame_t    frames_due[$];    // frames predicted but not yet seen on the output
  byte_req_t byte_reqs[$];     // requests waiting for the driver

  int unsigned bytes_pushed   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned bytes_dropped  = 0;
  int unsigned frames_checked = 0;
  int unsigned limit_cuts     = 0;
  int unsigned idents_written = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  bit          holding        = 1'b0;

  function automatic void clear_message();
    frame_seq   = '0;
    chunk_fill  = '0;
    chunk_bytes = '0;
    msg_total   = '0;
  endfunction

  // fold one byte into the current chunk and queue the frame it completes
  task automatic segment_byte(input logic [7:0] b, input logic fin);
    frame_t     f;
    logic [3:0] cnt;
    if (skipping) begin
      // past the frame limit: drop everything up to the last byte
      bytes_dropped++;
      if (fin) skipping = 1'b0;
      return;
    end
    chunk_bytes = chunk_bytes | (PAYLOAD_W'(b) << (8 * chunk_fill));
    cnt = {1'b0, chunk_fill} + 4'd1;
    f.frame_id = can_ident;
    f.payload  = chunk_bytes;
    if (fin) begin
      // final frame carries however many bytes were gathered
      msg_total     = msg_total + 8'(cnt);
      f.frame_len   = cnt + 4'd1;
      f.header_byte = FINAL_HDR | {4'd0, cnt};
      f.last_frame  = 1'b1;
      f.bytes_sent  = msg_total;
      frames_due.push_back(f);
      clear_message();
      return;
    end
    if (cnt < 4'(CHUNK_BYTES)) begin
      chunk_fill = cnt[2:0];
      return;
    end
    // full chunk, not the end of the message: middle frame
    msg_total     = msg_total + 8'(CHUNK_BYTES);
    f.frame_len   = FULL_LEN;
    f.header_byte = {frame_seq, 3'b000} | MIDDLE_LOW;
    f.last_frame  = (frame_seq == LAST_SEQ);
    f.bytes_sent  = msg_total;
    frames_due.push_back(f);
    if (frame_seq == LAST_SEQ) begin
      // frame limit reached: message ends here, rest of it is dropped
      limit_cuts++;
      clear_message();
      skipping = 1'b1;
    end else begin
      frame_seq   = frame_seq + SEQ_W'(1);
      chunk_fill  = '0;
      chunk_bytes = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued byte requests, predicts each one it hands over
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_req_t req;
    if (rst) begin
      holding  = 1'b0;
      in_valid <= 1'b0;
    end else begin
      if (holding && in_ready) begin
        segment_byte(data_byte, last_byte);
        bytes_taken++;
        holding = 1'b0;
      end
      // a new request goes out only when a random draw clears send_idle_pct; a drain-marked one
      // also waits until the output side has caught up completely
      if (!holding && byte_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct &&
          !(byte_reqs[0].drain_first && frames_due.size() != 0)) begin
        req = byte_reqs.pop_front();
        data_byte <= req.data;
        last_byte <= req.fin;
        holding   = 1'b1;
      end
      // valid assigned once per edge so a back-to-back request never dips
      in_valid <= holding;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes frames under random back-pressure, checks the oldest one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{frame_id: frame_id, frame_len: frame_len, header_byte: header_byte,
                payload: payload, last_frame: last_frame, bytes_sent: bytes_sent};
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected frame: id=%h len=%0d hdr=%h data=%h last=%b sent=%0d",
                     got.frame_id, got.frame_len, got.header_byte, got.payload,
                     got.last_frame, got.bytes_sent);
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (got.frame_id !== want.frame_id || got.frame_len !== want.frame_len ||
              got.header_byte !== want.header_byte || got.payload !== want.payload ||
              got.last_frame !== want.last_frame || got.bytes_sent !== want.bytes_sent)
          begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("frame %0d mismatch", frames_checked);
              $display("  expected id=%h len=%0d hdr=%h data=%h last=%b sent=%0d",
                       want.frame_id, want.frame_len, want.header_byte, want.payload,
                       want.last_frame, want.bytes_sent);
              $display("  actual   id=%h len=%0d hdr=%h data=%h last=%b sent=%0d",
                       got.frame_id, got.frame_len, got.header_byte, got.payload,
                       got.last_frame, got.bytes_sent);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no request moving on either side for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no request moved for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // queue one whole message; fill < 0 gives random bytes, else a fixed value
  task automatic add_msg(input int len, input int fill, input bit drain);
    byte_req_t req;
    for (int i = 0; i < len; i++) begin
      req.data        = (fill < 0) ? 8'($urandom) : 8'(fill);
      req.fin         = (i == len - 1);
      req.drain_first = drain && (i == 0);
      byte_reqs.push_back(req);
      bytes_pushed++;
    end
  endtask

  // every request taken, every frame seen, then room for a frame in flight
  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_taken != bytes_pushed || frames_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // identifier write, only ever issued while the block is idle
  task automatic write_ident(input logic [ID_W-1:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    can_ident = v;
    idents_written++;
  endtask

  // ---------------------------------------------------------------------------
  // sequencer: reset, then one idling phase after another
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    int unsigned r;
    int          msgs;
    int          len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // idling mix: none, sender gaps, receiver stalls, both
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // identifier: reset value first, then both extremes and a random one
      case (ph)
        0: ;
        1: write_ident('0);
        2: write_ident('1);
        default: write_ident(ID_W'($urandom_range(1, 2046)));
      endcase

      phase_start = bytes_pushed;
      if (ph == 0) begin
        // directed: single-byte messages at both byte extremes, a final
        // frame holding a full chunk, a middle frame then a one-byte final
        add_msg(1, 8'h00, 1'b0);
        add_msg(1, 8'hFF, 1'b0);
        add_msg(7, 8'hFF, 1'b0);
        add_msg(8, 8'h00, 1'b0);
        add_msg(2, -1, 1'b0);
        // exactly the frame limit, ending on its own last byte
        add_msg(32 * CHUNK_BYTES, -1, 1'b0);
      end else begin
        // past the frame limit, so the tail is dropped
        add_msg($urandom_range(32 * CHUNK_BYTES + 1, 260), -1, 1'b0);
      end

      msgs = 0;
      while (bytes_pushed - phase_start < PHASE_BYTES) begin
        // mostly short messages, some medium, a few long ones that can reach the cut
        r = $urandom_range(99);
        if (r < 70)      len = $urandom_range(1, 20);
        else if (r < 90) len = $urandom_range(21, 60);
        else             len = $urandom_range(200, 240);
        // the fourth message waits for the frame stream to drain first
        add_msg(len, -1, msgs == 3);
        msgs++;
      end
      wait_drained();
    end

    $display("covered %0d byte requests in %0d idling phases with %0d identifier writes",
             bytes_taken, NUM_PHASES, idents_written);
    $display("checked %0d frames, %0d limit cuts, %0d bytes dropped, %0d mismatches",
             frames_checked, limit_cuts, bytes_dropped, mismatches);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cps_pkg.sv
sv/cps_segment.sv
sv/cps_out_buf.sv
sv/can_payload_segmenter.sv
sv/cps_checker.sv
sim/can_payload_segmenter_tb.sv
